/* src/aas_pkg.sv */
// Shared types and constants for the adaptive access sampler.
// Used by the table, the divider and the top level; no dependencies.
package aas_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int ADDRESS_BITS = 48;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int TAG_W = ADDRESS_BITS - IDX_W;

	localparam int CNT_W = 32;
	localparam int RATE_W = 10;
	localparam int BUDGET_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// width of count * rate; the divider datapath uses the same width, over a 10-bit divisor
	localparam int DIVD_W = CNT_W + RATE_W;
	localparam int DIVS_W = RATE_W;

	localparam logic [DIVS_W-1:0] PER_MILLE = DIVS_W'(1000);

	// x / 1000 = ((x >> 3) * ceil(2^46 / 125)) >> 46, exact for the 39-bit shifted product;
	// the reciprocal is applied in two 20-bit halves
	localparam int PM_SHIFT = 3;
	localparam int PM_Y_W = DIVD_W - PM_SHIFT;
	localparam int PM_HALF_W = 20;
	localparam int PM_RECIP_SHIFT = 46;
	localparam int PM_ACC_W = PM_Y_W + PM_HALF_W;
	localparam int PM_QUO_W = PM_ACC_W - (PM_RECIP_SHIFT - PM_HALF_W);
	localparam logic [PM_HALF_W-1:0] PM_RECIP_LO = PM_HALF_W'(956302);
	localparam logic [PM_HALF_W-1:0] PM_RECIP_HI = PM_HALF_W'(536870);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADAPTIVE_MODE = 3'd0,
		CFG_RATE_DIVISOR = 3'd1,
		CFG_INITIAL_RATE = 3'd2,
		CFG_INITIAL_SAMPLE = 3'd3,
		CFG_INITIAL_SKIP = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic valid;
		logic [TAG_W-1:0] tag;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] sample;
		logic [CNT_W-1:0] skip;
		logic [RATE_W-1:0] rate;
	} entry_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
		entry_t entry;
	} tbl_wr_t;

	typedef struct packed {
		logic start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* src/aas_table.sv */
// Entry table of the sampler: one memory, one write and one registered read per cycle.
// Clears every entry after reset, one per cycle. Depends on aas_pkg.
module aas_table
	import aas_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [IDX_W-1:0] rd_idx,
	output entry_t rd_entry,
	input tbl_wr_t wr,
	output logic ready
);

	entry_t mem [TABLE_ENTRIES];
	entry_t rd_entry_q;
	logic clr_q;
	logic [IDX_W-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr.en) begin
			mem[wr.idx] <= wr.entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_idx];
		end
	end

	assign rd_entry = rd_entry_q;
	assign ready = !clr_q;

endmodule

/* src/aas_div.sv */
// Restoring divider, one quotient bit per cycle while busy, until all DIVD_W quotient bits are in.
// Decays the rate by the configured divisor. Depends on aas_pkg.
module aas_div
	import aas_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(DIVD_W + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVD_W - 1);

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVS_W:0] trial;
	logic fits;

	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when the divisor fits
			if (fits) begin
				rem_q <= DIVS_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DIVS_W-1:0];
			end
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* src/adaptive_access_sampler.sv */
// Adaptive access sampler: decides per memory access whether it goes to race checking.
// From accept to the result: with no rate update the result follows S_EVAL; a fixed-rate update
// adds S_MUL, S_KLO, S_KHI and S_KWR for the per-mille scaling, and an adaptive update first
// waits in S_RDIV for the rate division on the divider.
// One access at a time, busy meanwhile; the next is taken at the edge that takes the result.
// After reset the table clears all 1024 entries with busy high; done cannot be stalled.
module adaptive_access_sampler
	import aas_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [ADDRESS_BITS-1:0] instr_address,
	input logic [15:0] thread_id,
	input logic is_write,
	output logic done,
	output logic sampled,
	output logic [15:0] out_thread_id,
	output logic out_is_write,
	output logic rate_updated,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EVAL = 7'b0000010,
		S_RDIV = 7'b0000100,
		S_MUL = 7'b0001000,
		S_KLO = 7'b0010000,
		S_KHI = 7'b0100000,
		S_KWR = 7'b1000000
	} state_t;

	state_t state_q;

	logic adaptive_q;
	logic [RATE_W-1:0] divisor_q;
	logic [RATE_W-1:0] init_rate_q;
	logic [BUDGET_W-1:0] init_sample_q;
	logic [BUDGET_W-1:0] init_skip_q;

	logic [TAG_W-1:0] tag_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0] tid_q;
	logic wr_q;
	entry_t wk_q;
	logic [DIVD_W-1:0] prod_q;
	logic [PM_ACC_W-1:0] scale_q;

	logic done_q;
	logic sampled_q;
	logic updated_q;
	logic [15:0] out_tid_q;
	logic out_wr_q;

	logic accept;
	logic tbl_ready;
	entry_t rd_entry;
	tbl_wr_t tbl_wr;
	div_req_t div_req;
	div_rsp_t div_rsp;

	entry_t base;
	entry_t upd;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] samp_dec;
	logic need_update;
	logic sample_now;
	logic [RATE_W-1:0] div_eff;
	logic [RATE_W-1:0] rate_decayed;
	logic [PM_Y_W-1:0] pm_y;
	logic [PM_QUO_W-1:0] pm_quo;
	logic [PM_QUO_W-1:0] samp_capped;
	logic [CNT_W-1:0] samp;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE) || !tbl_ready;
	assign cfg_ready = 1'b1;
	assign div_eff = (divisor_q == '0) ? RATE_W'(1) : divisor_q;

	aas_table u_table (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_idx(instr_address[IDX_W-1:0]),
		.rd_entry(rd_entry),
		.wr(tbl_wr),
		.ready(tbl_ready)
	);

	aas_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	// hit check, replacement and the budget rule
	always_comb begin
		if (rd_entry.valid && rd_entry.tag == tag_q) begin
			base = rd_entry;
		end else begin
			base.valid = 1'b1;
			base.tag = tag_q;
			base.count = '0;
			base.sample = CNT_W'(init_sample_q);
			base.skip = CNT_W'(init_skip_q);
			base.rate = init_rate_q;
		end
		cnt_inc = (base.count == '1) ? base.count : base.count + 1'b1;
		samp_dec = (base.sample != '0) ? base.sample - 1'b1 : base.sample;
		upd = base;
		upd.count = cnt_inc;
		need_update = 1'b0;
		sample_now = 1'b0;
		if (base.skip == '0) begin
			upd.sample = samp_dec;
			if (samp_dec != '0) begin
				sample_now = 1'b1;
			end else begin
				need_update = 1'b1;
			end
		end else if (base.sample == '0) begin
			need_update = 1'b1;
		end else begin
			upd.skip = base.skip - 1'b1;
		end
	end

	assign rate_decayed = (div_rsp.quotient == '0) ? RATE_W'(1)
		: div_rsp.quotient[RATE_W-1:0];

	// per-mille scaling of count * rate by reciprocal multiplication
	assign pm_y = prod_q[DIVD_W-1:PM_SHIFT];
	assign pm_quo = scale_q[PM_ACC_W-1:PM_ACC_W-PM_QUO_W];
	assign samp_capped = (pm_quo > PM_QUO_W'(wk_q.count)) ? PM_QUO_W'(wk_q.count) : pm_quo;
	assign samp = samp_capped[CNT_W-1:0];

	always_comb begin
		div_req.start = 1'b0;
		div_req.dividend = DIVD_W'(base.rate);
		div_req.divisor = div_eff;
		tbl_wr.en = 1'b0;
		tbl_wr.idx = idx_q;
		tbl_wr.entry = upd;
		case (state_q)
			S_EVAL: begin
				div_req.start = need_update && adaptive_q;
				tbl_wr.en = !need_update;
			end
			S_KWR: begin
				tbl_wr.en = 1'b1;
				tbl_wr.entry = wk_q;
				tbl_wr.entry.sample = samp;
				tbl_wr.entry.skip = wk_q.count - samp;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adaptive_q <= 1'b1;
			divisor_q <= RATE_W'(10);
			init_rate_q <= RATE_W'(1000);
			init_sample_q <= BUDGET_W'(1);
			init_skip_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ADAPTIVE_MODE: adaptive_q <= cfg_data[0];
				CFG_RATE_DIVISOR: divisor_q <= cfg_data[RATE_W-1:0];
				CFG_INITIAL_RATE: init_rate_q <= cfg_data[RATE_W-1:0];
				CFG_INITIAL_SAMPLE: init_sample_q <= cfg_data;
				CFG_INITIAL_SKIP: init_skip_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (!need_update) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (adaptive_q) begin
						state_q <= S_RDIV;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_RDIV: begin
					if (div_rsp.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_KLO;
				S_KLO: state_q <= S_KHI;
				S_KHI: state_q <= S_KWR;
				S_KWR: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q <= instr_address[ADDRESS_BITS-1:IDX_W];
			idx_q <= instr_address[IDX_W-1:0];
			tid_q <= thread_id;
			wr_q <= is_write;
		end
		case (state_q)
			S_EVAL: begin
				wk_q <= upd;
				sampled_q <= sample_now;
				updated_q <= need_update;
				out_tid_q <= tid_q;
				out_wr_q <= wr_q;
			end
			S_RDIV: begin
				if (div_rsp.done) begin
					wk_q.rate <= rate_decayed;
				end
			end
			S_MUL: begin
				prod_q <= DIVD_W'(wk_q.count) * DIVD_W'(wk_q.rate);
			end
			S_KLO: begin
				scale_q <= PM_ACC_W'(pm_y) * PM_ACC_W'(PM_RECIP_LO);
			end
			S_KHI: begin
				// fold in the upper reciprocal half; the low partial product is shifted down by PM_HALF_W first
				scale_q <= (scale_q >> PM_HALF_W) + PM_ACC_W'(pm_y) * PM_ACC_W'(PM_RECIP_HI);
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign sampled = sampled_q;
	assign rate_updated = updated_q;
	assign out_thread_id = out_tid_q;
	assign out_is_write = out_wr_q;

endmodule

/* test/testbench.sv */
// Self-checking testbench for adaptive_access_sampler: directed and random access traffic,
// checked against an in-bench model of the tagged sampling table.
// Depends on aas_pkg for widths and register indexes.
module testbench
	import aas_pkg::*;
;

	localparam int unsigned DRAIN_LIMIT = 20000;
	localparam int unsigned TAIL_CYCLES = 100;
	localparam int unsigned ITEMS_PER_PHASE = 325;
	localparam int unsigned RANDOM_PHASES = 6;
	localparam int unsigned HOT_ADDRS = 16;

	typedef struct packed {
		logic sampled;
		logic [15:0] thread_id;
		logic is_write;
		logic rate_updated;
	} access_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [ADDRESS_BITS-1:0] instr_address = '0;
	logic [15:0] thread_id = '0;
	logic is_write = 1'b0;
	logic done;
	logic sampled;
	logic [15:0] out_thread_id;
	logic out_is_write;
	logic rate_updated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register mirror, reset values
	logic mdl_adaptive = 1'b1;
	logic [RATE_W-1:0] mdl_divisor = RATE_W'(10);
	logic [RATE_W-1:0] mdl_init_rate = RATE_W'(1000);
	logic [BUDGET_W-1:0] mdl_init_sample = BUDGET_W'(1);
	logic [BUDGET_W-1:0] mdl_init_skip = '0;

	// sampling table mirror
	bit slot_valid [TABLE_ENTRIES];
	logic [TAG_W-1:0] slot_tag [TABLE_ENTRIES];
	logic [CNT_W-1:0] slot_count [TABLE_ENTRIES];
	logic [CNT_W-1:0] slot_sample [TABLE_ENTRIES];
	logic [CNT_W-1:0] slot_skip [TABLE_ENTRIES];
	logic [RATE_W-1:0] slot_rate [TABLE_ENTRIES];

	access_result_t pending_results[$];

	int unsigned sender_idle_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned accesses_sent = 0;
	int unsigned results_seen = 0;
	int unsigned sampled_seen = 0;
	int unsigned updates_seen = 0;
	int unsigned settings_applied = 0;

	adaptive_access_sampler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.instr_address(instr_address),
		.thread_id(thread_id),
		.is_write(is_write),
		.done(done),
		.sampled(sampled),
		.out_thread_id(out_thread_id),
		.out_is_write(out_is_write),
		.rate_updated(rate_updated),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void recompute_budgets(input int unsigned s);
		logic [RATE_W-1:0] r;
		logic [RATE_W-1:0] d;
		logic [63:0] quota;
		r = slot_rate[s];
		if (mdl_adaptive) begin
			// a zero divisor acts as a divisor of one
			d = (mdl_divisor == '0) ? RATE_W'(1) : mdl_divisor;
			r = r / d;
			if (r == '0)
				r = RATE_W'(1);
		end
		slot_rate[s] = r;
		quota = (64'(slot_count[s]) * 64'(r)) / 64'(PER_MILLE);
		if (quota > 64'(slot_count[s]))
			quota = 64'(slot_count[s]);
		slot_sample[s] = quota[CNT_W-1:0];
		slot_skip[s] = slot_count[s] - quota[CNT_W-1:0];
	endfunction

	function automatic access_result_t predict_access(input logic [ADDRESS_BITS-1:0] addr,
			input logic [15:0] tid, input logic wr);
		access_result_t res;
		int unsigned s;
		logic [TAG_W-1:0] tg;
		s = int'(addr[IDX_W-1:0]);
		tg = addr[ADDRESS_BITS-1:IDX_W];
		res = '{sampled: 1'b0, thread_id: tid, is_write: wr, rate_updated: 1'b0};
		if (!slot_valid[s] || slot_tag[s] != tg) begin
			slot_valid[s] = 1'b1;
			slot_tag[s] = tg;
			slot_count[s] = '0;
			slot_sample[s] = CNT_W'(mdl_init_sample);
			slot_skip[s] = CNT_W'(mdl_init_skip);
			slot_rate[s] = mdl_init_rate;
		end
		if (slot_count[s] != '1)
			slot_count[s] = slot_count[s] + 1'b1;
		if (slot_skip[s] == '0) begin
			if (slot_sample[s] != '0)
				slot_sample[s] = slot_sample[s] - 1'b1;
			if (slot_sample[s] != '0) begin
				res.sampled = 1'b1;
			end else begin
				recompute_budgets(s);
				res.rate_updated = 1'b1;
			end
		end else if (slot_sample[s] == '0) begin
			recompute_budgets(s);
			res.rate_updated = 1'b1;
		end else begin
			slot_skip[s] = slot_skip[s] - 1'b1;
		end
		return res;
	endfunction

	// start stays high after acceptance; the next call or a drain drives it at its own negedge
	task automatic send_access(input logic [ADDRESS_BITS-1:0] addr, input logic [15:0] tid,
			input logic wr);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		instr_address = addr;
		thread_id = tid;
		is_write = wr;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(predict_access(addr, tid, wr));
		accesses_sent++;
	endtask

	task automatic wait_results_drained();
		int unsigned waited;
		waited = 0;
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			mismatch_count++;
			$display("drain stalled: %0d results still outstanding", pending_results.size());
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_ADAPTIVE_MODE: mdl_adaptive = value[0];
			CFG_RATE_DIVISOR: mdl_divisor = value[RATE_W-1:0];
			CFG_INITIAL_RATE: mdl_init_rate = value[RATE_W-1:0];
			CFG_INITIAL_SAMPLE: mdl_init_sample = value[BUDGET_W-1:0];
			CFG_INITIAL_SKIP: mdl_init_skip = value[BUDGET_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_settings(input logic adaptive, input logic [CFG_DATA_W-1:0] divisor,
			input logic [CFG_DATA_W-1:0] rate, input logic [CFG_DATA_W-1:0] sample_init,
			input logic [CFG_DATA_W-1:0] skip_init);
		wait_results_drained();
		write_reg(CFG_ADAPTIVE_MODE, CFG_DATA_W'(adaptive));
		write_reg(CFG_RATE_DIVISOR, divisor);
		write_reg(CFG_INITIAL_RATE, rate);
		write_reg(CFG_INITIAL_SAMPLE, sample_init);
		write_reg(CFG_INITIAL_SKIP, skip_init);
		settings_applied++;
	endtask

	// reset settings: every access ends in a rate update and the rate decays by ten
	task automatic test_reset_defaults();
		send_access('0, 16'h0000, 1'b0);
		send_access('0, 16'hFFFF, 1'b1);
		send_access('0, 16'h1234, 1'b0);
	endtask

	task automatic test_field_extremes();
		send_access('1, 16'hFFFF, 1'b1);
		send_access(ADDRESS_BITS'(48'h0000_0000_03FF), 16'h0001, 1'b0);
		send_access('1, 16'h8000, 1'b1);
		send_access(ADDRESS_BITS'(48'hAAAA_AAAA_AAAA), 16'hAAAA, 1'b0);
		send_access(ADDRESS_BITS'(48'h5555_5555_5555), 16'h5555, 1'b1);
	endtask

	task automatic test_zero_budgets();
		// sample budget already empty with no skip: decrement holds at zero
		apply_settings(1'b1, 16'd10, 16'd1000, 16'd0, 16'd0);
		send_access(ADDRESS_BITS'(48'h1000_0000_0010), 16'h0010, 1'b0);
		send_access(ADDRESS_BITS'(48'h1000_0000_0010), 16'h0011, 1'b1);
		apply_settings(1'b0, 16'd10, 16'd500, 16'd0, 16'hFFFF);
		send_access(ADDRESS_BITS'(48'h1000_0000_0020), 16'h0020, 1'b0);
		apply_settings(1'b0, 16'd10, 16'd500, 16'hFFFF, 16'd0);
		send_access(ADDRESS_BITS'(48'h1000_0000_0030), 16'h0030, 1'b1);
		send_access(ADDRESS_BITS'(48'h1000_0000_0030), 16'h0031, 1'b0);
		apply_settings(1'b1, 16'd10, 16'd500, 16'd2, 16'd2);
		send_access(ADDRESS_BITS'(48'h1000_0000_0040), 16'h0040, 1'b1);
	endtask

	task automatic test_rate_extremes();
		// zero divisor behaves as one
		apply_settings(1'b1, 16'd0, 16'd1000, 16'd1, 16'd0);
		send_access(ADDRESS_BITS'(48'h2000_0000_0050), 16'h0050, 1'b0);
		send_access(ADDRESS_BITS'(48'h2000_0000_0050), 16'h0051, 1'b1);
		apply_settings(1'b1, 16'd1000, 16'd1023, 16'd1, 16'd0);
		send_access(ADDRESS_BITS'(48'h2000_0000_0060), 16'h0060, 1'b0);
		send_access(ADDRESS_BITS'(48'h2000_0000_0060), 16'h0061, 1'b1);
		// a rate above 1000 brings the sample budget up to the count
		apply_settings(1'b0, 16'd1, 16'd1023, 16'd1, 16'd0);
		send_access(ADDRESS_BITS'(48'h2000_0000_0070), 16'h0070, 1'b0);
		send_access(ADDRESS_BITS'(48'h2000_0000_0070), 16'h0071, 1'b1);
		apply_settings(1'b0, 16'd1, 16'd0, 16'd1, 16'd0);
		send_access(ADDRESS_BITS'(48'h2000_0000_0080), 16'h0080, 1'b0);
		send_access(ADDRESS_BITS'(48'h2000_0000_0080), 16'h0081, 1'b1);
	endtask

	task automatic test_random_traffic();
		logic [ADDRESS_BITS-1:0] hot_addr [HOT_ADDRS];
		logic [ADDRESS_BITS-1:0] addr;
		logic [CFG_DATA_W-1:0] divisor;
		logic [CFG_DATA_W-1:0] sample_init;
		logic [CFG_DATA_W-1:0] skip_init;
		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			sender_idle_pct = (p < 2) ? 17 : ((p < 4) ? 64 : 0);
			divisor = ($urandom_range(1) == 0) ? CFG_DATA_W'($urandom_range(1, 4))
				: CFG_DATA_W'($urandom_range(1, 1000));
			sample_init = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(65535))
				: CFG_DATA_W'($urandom_range(0, 12));
			skip_init = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(65535))
				: CFG_DATA_W'($urandom_range(0, 12));
			apply_settings(p[0], divisor, CFG_DATA_W'($urandom_range(1, 1000)), sample_init,
				skip_init);
			// upper half of the pool shares slots with the lower half to force evictions
			for (int unsigned h = 0; h < HOT_ADDRS; h++) begin
				hot_addr[h] = ADDRESS_BITS'({$urandom, $urandom});
				if (h >= HOT_ADDRS / 2)
					hot_addr[h][IDX_W-1:0] = hot_addr[h - HOT_ADDRS / 2][IDX_W-1:0];
			end
			for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2 || $urandom_range(99) == 0)
					wait_results_drained();
				addr = ($urandom_range(99) < 85) ? hot_addr[$urandom_range(HOT_ADDRS - 1)]
					: ADDRESS_BITS'({$urandom, $urandom});
				send_access(addr, 16'($urandom), 1'($urandom));
			end
		end
		sender_idle_pct = 0;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (sampled)
				sampled_seen++;
			if (rate_updated)
				updates_seen++;
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result at %0t: tid %h", $time, out_thread_id);
				mismatch_count++;
			end else begin
				access_result_t exp_res;
				exp_res = pending_results.pop_front();
				if (sampled !== exp_res.sampled || out_thread_id !== exp_res.thread_id
						|| out_is_write !== exp_res.is_write
						|| rate_updated !== exp_res.rate_updated) begin
					if (mismatch_count < 10)
						$display({"mismatch at %0t (exp/act): sampled %0b/%0b tid %h/%h ",
							"write %0b/%0b rate_updated %0b/%0b"}, $time,
							exp_res.sampled, sampled, exp_res.thread_id, out_thread_id,
							exp_res.is_write, out_is_write, exp_res.rate_updated,
							rate_updated);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		for (int unsigned s = 0; s < TABLE_ENTRIES; s++)
			slot_valid[s] = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_field_extremes();
		test_zero_budgets();
		test_rate_extremes();
		test_random_traffic();
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d accesses over %0d register settings: %0d results, %0d sampled, %0d rate updates",
			accesses_sent, settings_applied + 1, results_seen, sampled_seen, updates_seen);
		$display("%0d failures, %0d results still outstanding", mismatch_count,
			pending_results.size());
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#12000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
